// ----- hdl/lpg_pkg.sv -----
// Package for the laser line point generator.
// Holds widths, constants, controller/datapath command and status types,
// and the saturation helper. No dependencies.
package lpg_pkg;

    localparam int COORD_W      = 16;
    localparam int DELTA_W      = 17;
    localparam int SPACING_W    = 16;
    localparam int IDX_W        = 18;
    localparam int SQ_W         = 34;
    localparam int ROOT_W       = 17;
    localparam int SQREM_W      = 20;
    localparam int NUM_W        = 36;
    localparam int CNT_W        = 7;
    localparam int STEP_W       = 6;
    localparam int LEVEL_W      = 16;

    localparam int MAX_BODY_POINTS = 64;
    localparam int EDGE_POINTS     = 10;

    localparam logic [SPACING_W-1:0] SPACING_RESET = 16'd300;
    localparam logic [LEVEL_W-1:0]   LEVEL_FULL    = 16'hFFFF;

    localparam logic [STEP_W-1:0] SQRT_STEPS = STEP_W'(ROOT_W);
    localparam logic [STEP_W-1:0] DIV_STEPS  = STEP_W'(NUM_W);

    // Segment part selector codes
    localparam logic [1:0] FUNC_BODY    = 2'd0;
    localparam logic [1:0] FUNC_LEAD_IN = 2'd1;
    localparam logic [1:0] FUNC_LEAD_OUT = 2'd2;
    // Unused selector, gives no points
    localparam logic [1:0] FUNC_NONE    = 2'd3;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic sq;
        logic sqrt_init;
        logic sqrt_step;
        logic div_init_len;
        logic div_init_pt;
        logic div_step;
        logic cap;
        logic mul_a;
        logic mul_b;
        logic out_load;
        logic next_pt;
    } lpg_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic count_zero;
        logic last_pt;
    } lpg_stat_t;

    // Apply sign to a magnitude and clamp to signed 16 bits
    function automatic logic signed [COORD_W-1:0] sat16(input logic neg,
                                                        input logic [NUM_W-1:0] mag);
        logic signed [COORD_W-1:0] res;
        if (!neg) begin
            if (mag > NUM_W'(32767))
                res = 16'sh7FFF;
            else
                res = COORD_W'(mag);
        end
        else begin
            if (mag > NUM_W'(32768))
                res = 16'sh8000;
            else
                res = COORD_W'(~mag + NUM_W'(1));
        end
        return res;
    endfunction

endpackage

// ----- hdl/laser_line_point_generator_top.sv -----
// Top level of the laser line point generator.
// Instantiates lpg_controller and lpg_datapath; depends on lpg_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one segment beat: func, the two
//   endpoints and visible. in_ready is high only while the block is idle.
//   Output channel (out_valid/out_ready) gives the points of that segment,
//   one beat each, last_point set on the final one. Invisible segments,
//   func 3 and bodies shorter than the spacing give no beats.
//   Config channel (cfg_valid/cfg_ready, cfg_data) writes point_spacing;
//   cfg_ready is always high, write only while idle. Spacing 0 acts as 1.
// Sequence:
//   Body setup: square, root init, 17 root steps, divider init, 36 divide
//   steps, cap. Each point: multiply a*den, add i*d, divider init, 36 divide
//   steps (restoring divider, one quotient bit per cycle), result load, then
//   the output beat. An edge run gives 10 points.
// Reset: asynchronous; returns to idle, spacing back to 300.
// Stall: while out_ready is low the result is held and no work proceeds.
module laser_line_point_generator_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lpg_pkg::SPACING_W-1:0]        cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           func,
    input  logic signed [lpg_pkg::COORD_W-1:0]   start_x,
    input  logic signed [lpg_pkg::COORD_W-1:0]   start_y,
    input  logic signed [lpg_pkg::COORD_W-1:0]   end_x,
    input  logic signed [lpg_pkg::COORD_W-1:0]   end_y,
    input  logic                                 visible,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [lpg_pkg::COORD_W-1:0]   point_x,
    output logic signed [lpg_pkg::COORD_W-1:0]   point_y,
    output logic [lpg_pkg::LEVEL_W-1:0]          red_level,
    output logic [lpg_pkg::LEVEL_W-1:0]          green_level,
    output logic [lpg_pkg::LEVEL_W-1:0]          blue_level,
    output logic                                 clipped,
    output logic                                 last_point
);
    import lpg_pkg::*;

    lpg_cmd_t  cmd;
    lpg_stat_t stat;

    assign cfg_ready  = 1'b1;
    assign red_level  = '0;
    assign blue_level = '0;

    lpg_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .visible   (visible),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    lpg_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .func        (func),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .point_x     (point_x),
        .point_y     (point_y),
        .green_level (green_level),
        .clipped     (clipped),
        .last_point  (last_point)
    );

endmodule

// ----- hdl/lpg_datapath.sv -----
// Datapath of the laser line point generator: segment registers, squarer,
// bit-pair square root, two restoring divider lanes and the result register.
// Depends on lpg_pkg.
module lpg_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lpg_pkg::lpg_cmd_t                    cmd,
    output lpg_pkg::lpg_stat_t                   stat,
    input  logic                                 cfg_valid,
    input  logic [lpg_pkg::SPACING_W-1:0]        cfg_data,
    input  logic [1:0]                           func,
    input  logic signed [lpg_pkg::COORD_W-1:0]   start_x,
    input  logic signed [lpg_pkg::COORD_W-1:0]   start_y,
    input  logic signed [lpg_pkg::COORD_W-1:0]   end_x,
    input  logic signed [lpg_pkg::COORD_W-1:0]   end_y,
    output logic signed [lpg_pkg::COORD_W-1:0]   point_x,
    output logic signed [lpg_pkg::COORD_W-1:0]   point_y,
    output logic [lpg_pkg::LEVEL_W-1:0]          green_level,
    output logic                                 clipped,
    output logic                                 last_point
);
    import lpg_pkg::*;

    logic [SPACING_W-1:0]          spacing_reg;
    logic [SPACING_W-1:0]          spacing_eff;
    logic signed [COORD_W-1:0]     ax_reg, ay_reg;
    logic signed [DELTA_W-1:0]     dx_reg, dy_reg;
    logic [SPACING_W-1:0]          den_reg;
    logic signed [IDX_W-1:0]       i_reg;
    logic [CNT_W-1:0]              count_reg, k_reg;
    logic                          clip_reg, green_reg;
    logic [31:0]                   sqx_reg, sqy_reg;
    logic [SQ_W-1:0]               sq_src_reg;
    logic [SQREM_W-1:0]            sq_rem_reg;
    logic [ROOT_W-1:0]             root_reg;
    logic signed [32:0]            pax_reg, pay_reg;
    logic signed [NUM_W-1:0]       numx_reg, numy_reg;
    logic [NUM_W-1:0]              qx_reg, qy_reg;
    logic [SPACING_W-1:0]          rx_reg, ry_reg;
    logic                          negx_reg, negy_reg;
    logic [DELTA_W-1:0]            ux, uy;
    logic [SQREM_W-1:0]            rem_sh, trial;
    logic [SPACING_W:0]            rsx, rsy;
    logic                          gex, gey;

    assign spacing_eff = (spacing_reg == '0) ? SPACING_W'(1) : spacing_reg;
    assign ux = dx_reg[DELTA_W-1] ? DELTA_W'(-dx_reg) : DELTA_W'(dx_reg);
    assign uy = dy_reg[DELTA_W-1] ? DELTA_W'(-dy_reg) : DELTA_W'(dy_reg);
    assign rem_sh = {sq_rem_reg[SQREM_W-3:0], sq_src_reg[SQ_W-1 -: 2]};
    assign trial  = SQREM_W'({root_reg, 2'b01});
    assign rsx = {rx_reg, qx_reg[NUM_W-1]};
    assign rsy = {ry_reg, qy_reg[NUM_W-1]};
    assign gex = rsx >= {1'b0, den_reg};
    assign gey = rsy >= {1'b0, den_reg};

    assign stat.count_zero = (count_reg == '0);
    assign stat.last_pt    = (k_reg == count_reg - CNT_W'(1));

    // Hold the spacing register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            spacing_reg <= SPACING_RESET;
        else if (cfg_valid)
            spacing_reg <= cfg_data;
    end

    // Segment, counters and arithmetic registers
    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            ax_reg    <= start_x;
            ay_reg    <= start_y;
            dx_reg    <= DELTA_W'(end_x) - DELTA_W'(start_x);
            dy_reg    <= DELTA_W'(end_y) - DELTA_W'(start_y);
            den_reg   <= spacing_eff;
            count_reg <= CNT_W'(EDGE_POINTS);
            k_reg     <= '0;
            clip_reg  <= 1'b0;
            green_reg <= (func != FUNC_LEAD_IN);
            if (func == FUNC_LEAD_IN)
                i_reg <= -IDX_W'(EDGE_POINTS);
            else if (func == FUNC_LEAD_OUT)
                i_reg <= IDX_W'(spacing_eff);
            else
                i_reg <= '0;
        end
        if (cmd.sq) begin
            sqx_reg <= 32'(ux[SPACING_W-1:0] * ux[SPACING_W-1:0]);
            sqy_reg <= 32'(uy[SPACING_W-1:0] * uy[SPACING_W-1:0]);
        end
        // Square root, two bits per step
        if (cmd.sqrt_init) begin
            sq_src_reg <= SQ_W'(sqx_reg) + SQ_W'(sqy_reg);
            sq_rem_reg <= '0;
            root_reg   <= '0;
        end
        if (cmd.sqrt_step) begin
            sq_src_reg <= {sq_src_reg[SQ_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                sq_rem_reg <= rem_sh - trial;
                root_reg   <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else begin
                sq_rem_reg <= rem_sh;
                root_reg   <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        // Divider lanes
        if (cmd.div_init_len) begin
            qx_reg   <= NUM_W'(root_reg);
            qy_reg   <= '0;
            rx_reg   <= '0;
            ry_reg   <= '0;
            negx_reg <= 1'b0;
            negy_reg <= 1'b0;
        end
        if (cmd.div_init_pt) begin
            negx_reg <= numx_reg[NUM_W-1];
            negy_reg <= numy_reg[NUM_W-1];
            qx_reg   <= numx_reg[NUM_W-1] ? NUM_W'(-numx_reg) : NUM_W'(numx_reg);
            qy_reg   <= numy_reg[NUM_W-1] ? NUM_W'(-numy_reg) : NUM_W'(numy_reg);
            rx_reg   <= '0;
            ry_reg   <= '0;
        end
        if (cmd.div_step) begin
            rx_reg <= gex ? SPACING_W'(rsx - {1'b0, den_reg}) : SPACING_W'(rsx);
            ry_reg <= gey ? SPACING_W'(rsy - {1'b0, den_reg}) : SPACING_W'(rsy);
            qx_reg <= {qx_reg[NUM_W-2:0], gex};
            qy_reg <= {qy_reg[NUM_W-2:0], gey};
        end
        // Cap the body point count
        if (cmd.cap) begin
            i_reg <= '0;
            if (qx_reg > NUM_W'(MAX_BODY_POINTS)) begin
                count_reg <= CNT_W'(MAX_BODY_POINTS);
                den_reg   <= SPACING_W'(MAX_BODY_POINTS);
                clip_reg  <= 1'b1;
            end
            else begin
                count_reg <= qx_reg[CNT_W-1:0];
                den_reg   <= SPACING_W'(qx_reg[CNT_W-1:0]);
            end
        end
        // Numerator a*den + i*d: a*den is registered first, then i*d is added
        if (cmd.mul_a) begin
            pax_reg <= 33'(ax_reg * $signed({1'b0, den_reg}));
            pay_reg <= 33'(ay_reg * $signed({1'b0, den_reg}));
        end
        if (cmd.mul_b) begin
            numx_reg <= NUM_W'(pax_reg) + NUM_W'(i_reg * dx_reg);
            numy_reg <= NUM_W'(pay_reg) + NUM_W'(i_reg * dy_reg);
        end
        if (cmd.next_pt) begin
            k_reg <= k_reg + CNT_W'(1);
            i_reg <= i_reg + IDX_W'(1);
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load) begin
            point_x     <= sat16(negx_reg, qx_reg);
            point_y     <= sat16(negy_reg, qy_reg);
            green_level <= green_reg ? LEVEL_FULL : '0;
            clipped     <= clip_reg;
            last_point  <= stat.last_pt;
        end
    end

endmodule

// ----- hdl/lpg_controller.sv -----
// Controller state machine of the laser line point generator.
// Sequences root, count division and per-point work; owns both handshakes.
// Depends on lpg_pkg.
module lpg_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          func,
    input  logic                visible,
    output logic                out_valid,
    input  logic                out_ready,
    output lpg_pkg::lpg_cmd_t   cmd,
    input  lpg_pkg::lpg_stat_t  stat
);
    import lpg_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_SQ        = 13'b0000000000010,
        S_SQRT_INIT = 13'b0000000000100,
        S_SQRT      = 13'b0000000001000,
        S_DIVN_INIT = 13'b0000000010000,
        S_DIVN      = 13'b0000000100000,
        S_CAP       = 13'b0000001000000,
        S_MUL_A     = 13'b0000010000000,
        S_MUL_B     = 13'b0000100000000,
        S_DIV_INIT  = 13'b0001000000000,
        S_DIV       = 13'b0010000000000,
        S_FIN       = 13'b0100000000000,
        S_OUT       = 13'b1000000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                in_beat;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign in_beat   = in_valid && in_ready;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    cmd.load = 1'b1;
                    if (!visible || func == FUNC_NONE)
                        state_next = S_IDLE;
                    else if (func == FUNC_BODY)
                        state_next = S_SQ;
                    else
                        state_next = S_MUL_A;
                end
            end
            S_SQ: begin
                cmd.sq     = 1'b1;
                state_next = S_SQRT_INIT;
            end
            S_SQRT_INIT: begin
                cmd.sqrt_init = 1'b1;
                step_next     = '0;
                state_next    = S_SQRT;
            end
            S_SQRT: begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg + STEP_W'(1);
                if (step_reg == SQRT_STEPS - STEP_W'(1))
                    state_next = S_DIVN_INIT;
            end
            S_DIVN_INIT: begin
                cmd.div_init_len = 1'b1;
                step_next        = '0;
                state_next       = S_DIVN;
            end
            S_DIVN: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == DIV_STEPS - STEP_W'(1))
                    state_next = S_CAP;
            end
            S_CAP: begin
                cmd.cap    = 1'b1;
                state_next = S_MUL_A;
            end
            S_MUL_A: begin
                // drop a body with no points
                if (stat.count_zero)
                    state_next = S_IDLE;
                else begin
                    cmd.mul_a  = 1'b1;
                    state_next = S_MUL_B;
                end
            end
            S_MUL_B: begin
                cmd.mul_b  = 1'b1;
                state_next = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                cmd.div_init_pt = 1'b1;
                step_next       = '0;
                state_next      = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == DIV_STEPS - STEP_W'(1))
                    state_next = S_FIN;
            end
            S_FIN: begin
                cmd.out_load = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (out_ready) begin
                    cmd.next_pt = 1'b1;
                    state_next  = stat.last_pt ? S_IDLE : S_MUL_A;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state and step count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output open together");

    a_body_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && visible && func == FUNC_BODY) |=> (state_reg == S_SQ))
        else $error("body beat did not start root");

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (step_reg < DIV_STEPS))
        else $error("divider ran past its width");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.out_load))
        else $error("result shown without load");

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for laser_line_point_generator_top.
// Predicts every point of each segment and checks the output beats in order.
// Depends on lpg_pkg and the RTL of the block.
`timescale 1ns / 1ps

class point_scoreboard;
    typedef struct {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic [15:0]        green;
        logic               clip;
        logic               last;
    } point_t;

    point_t      pending_points[$];
    logic [15:0] spacing;
    int          errors;
    int          checked;

    function new();
        spacing = lpg_pkg::SPACING_RESET;
        errors  = 0;
        checked = 0;
    endfunction

    // Integer square root by bit pairs
    function automatic longint unsigned int_root(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // a + i*d/den, truncated toward zero, clamped to 16 bits
    function automatic logic signed [15:0] lerp(longint a, longint d, longint i, longint den);
        longint q;
        q = (a * den + i * d) / den;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    // Note one accepted segment and queue its points
    function void add_segment(logic [1:0] fn, logic signed [15:0] ax, logic signed [15:0] ay,
                              logic signed [15:0] bx, logic signed [15:0] by, logic vis);
        longint dx, dy, sp, n, first, len;
        logic   clip;
        point_t p;
        dx = longint'(bx) - longint'(ax);
        dy = longint'(by) - longint'(ay);
        sp = (spacing == 0) ? 1 : spacing;
        if (!vis || fn == lpg_pkg::FUNC_NONE) return;
        if (fn == lpg_pkg::FUNC_BODY) begin
            len  = int_root(dx * dx + dy * dy);
            n    = len / sp;
            clip = 1'b0;
            if (n > lpg_pkg::MAX_BODY_POINTS) begin
                n    = lpg_pkg::MAX_BODY_POINTS;
                clip = 1'b1;
            end
            for (longint k = 0; k < n; k++) begin
                p.px = lerp(ax, dx, k, n);
                p.py = lerp(ay, dy, k, n);
                p.green = lpg_pkg::LEVEL_FULL;
                p.clip = clip;
                p.last = (k == n - 1);
                pending_points = {pending_points, p};
            end
        end
        else begin
            first = (fn == lpg_pkg::FUNC_LEAD_IN) ? -lpg_pkg::EDGE_POINTS : sp;
            for (longint k = 0; k < lpg_pkg::EDGE_POINTS; k++) begin
                p.px = lerp(ax, dx, first + k, sp);
                p.py = lerp(ay, dy, first + k, sp);
                p.green = (fn == lpg_pkg::FUNC_LEAD_IN) ? 16'd0 : lpg_pkg::LEVEL_FULL;
                p.clip = 1'b0;
                p.last = (k == lpg_pkg::EDGE_POINTS - 1);
                pending_points = {pending_points, p};
            end
        end
    endfunction

    // Compare one output beat with the oldest expected point
    function void check_point(logic signed [15:0] px, logic signed [15:0] py, logic [15:0] r,
                              logic [15:0] g, logic [15:0] b, logic c, logic l);
        point_t e;
        if (pending_points.size() == 0) begin
            $display("%0t: unexpected point x=%0d y=%0d", $time, px, py);
            errors++;
            return;
        end
        e = pending_points.pop_front();
        checked++;
        if (px !== e.px) begin
            $display("%0t: point_x expected %0d actual %0d", $time, e.px, px);
            errors++;
        end
        if (py !== e.py) begin
            $display("%0t: point_y expected %0d actual %0d", $time, e.py, py);
            errors++;
        end
        if (r !== 16'd0) begin
            $display("%0t: red_level expected 0 actual %0d", $time, r);
            errors++;
        end
        if (g !== e.green) begin
            $display("%0t: green_level expected %0d actual %0d", $time, e.green, g);
            errors++;
        end
        if (b !== 16'd0) begin
            $display("%0t: blue_level expected 0 actual %0d", $time, b);
            errors++;
        end
        if (c !== e.clip) begin
            $display("%0t: clipped expected %0b actual %0b", $time, e.clip, c);
            errors++;
        end
        if (l !== e.last) begin
            $display("%0t: last_point expected %0b actual %0b", $time, e.last, l);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import lpg_pkg::*;

    localparam longint CYCLE_LIMIT = 5000000;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [SPACING_W-1:0]      cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic [1:0]                func;
    logic signed [COORD_W-1:0] start_x, start_y, end_x, end_y;
    logic                      visible;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [COORD_W-1:0] point_x, point_y;
    logic [LEVEL_W-1:0]        red_level, green_level, blue_level;
    logic                      clipped;
    logic                      last_point;

    point_scoreboard sb;
    longint          cycles;
    int              segments;
    int              out_wait;

    laser_line_point_generator_top u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .func(func),
        .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
        .visible(visible),
        .out_valid(out_valid), .out_ready(out_ready),
        .point_x(point_x), .point_y(point_y),
        .red_level(red_level), .green_level(green_level), .blue_level(blue_level),
        .clipped(clipped), .last_point(last_point)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort on a hang
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** laser_line_point_generator_top: FAILED **");
            $finish;
        end
    end

    // Check each accepted output beat and draw the wait for the next one
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) begin
            sb.check_point(point_x, point_y, red_level, green_level, blue_level,
                           clipped, last_point);
            out_wait = $urandom_range(0, 5);
        end
    end

    // Hold ready low for the drawn wait once a beat is offered
    always @(negedge clk)
    begin
        if (out_wait > 0) begin
            out_ready <= 1'b0;
            if (out_valid)
                out_wait = out_wait - 1;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic send_segment(logic [1:0] fn, logic signed [15:0] ax, logic signed [15:0] ay,
                                logic signed [15:0] bx, logic signed [15:0] by, logic vis);
        int gap;
        gap = $urandom_range(0, 5);
        repeat (gap) @(negedge clk);
        in_valid = 1'b1;
        func = fn;
        start_x = ax;
        start_y = ay;
        end_x = bx;
        end_y = by;
        visible = vis;
        do @(posedge clk); while (!in_ready);
        sb.add_segment(fn, ax, ay, bx, by, vis);
        segments++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Wait until all points are out, then let the block settle
    task automatic drain();
        while (sb.pending_points.size() != 0) @(negedge clk);
        repeat (3000) @(negedge clk);
    endtask

    task automatic write_spacing(logic [15:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.spacing = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_coord(int span);
        if (span == 0) return 16'($urandom());
        return $signed(16'($urandom_range(0, 2 * span))) - 16'(span);
    endfunction

    task automatic random_segment(int span);
        logic signed [15:0] ax, ay;
        int                 r;
        logic [1:0]         fn;
        ax = rand_coord(span);
        ay = rand_coord(span);
        r  = $urandom_range(0, 19);
        fn = (r < 10) ? FUNC_BODY : (r < 14) ? FUNC_LEAD_IN : (r < 18) ? FUNC_LEAD_OUT : FUNC_NONE;
        send_segment(fn, ax, ay, ax + rand_coord(span), ay + rand_coord(span),
                     ($urandom_range(0, 9) != 0));
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        segments = 0;
        out_wait = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        func = FUNC_BODY;
        start_x = '0;
        start_y = '0;
        end_x = '0;
        end_y = '0;
        visible = 1'b0;
        out_ready = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset spacing, extremes, every part, special cases
        send_segment(FUNC_BODY, 0, 0, 3000, 4000, 1'b1);
        send_segment(FUNC_BODY, 0, 0, 100, 0, 1'b1);
        send_segment(FUNC_BODY, -32768, -32768, 32767, 32767, 1'b1);
        send_segment(FUNC_BODY, 32767, 32767, -32768, -32768, 1'b1);
        send_segment(FUNC_LEAD_IN, -32768, 32767, 32767, -32768, 1'b1);
        send_segment(FUNC_LEAD_OUT, 32767, -32768, -32768, 32767, 1'b1);
        send_segment(FUNC_LEAD_OUT, 100, -200, 700, 900, 1'b1);
        send_segment(FUNC_BODY, 5, 5, 20000, 5, 1'b0);
        send_segment(FUNC_NONE, 5, 5, 20000, 5, 1'b1);
        send_segment(FUNC_LEAD_IN, 0, 0, 0, 0, 1'b1);
        write_spacing(16'd0);
        send_segment(FUNC_BODY, 0, 0, 30, 40, 1'b1);
        send_segment(FUNC_LEAD_IN, -5, 7, 300, -300, 1'b1);
        send_segment(FUNC_LEAD_OUT, 32000, 32000, 32767, 32767, 1'b1);
        write_spacing(16'hFFFF);
        send_segment(FUNC_BODY, -32768, 0, 32767, 0, 1'b1);
        send_segment(FUNC_LEAD_OUT, -32768, -32768, 32767, 32767, 1'b1);
        send_segment(FUNC_LEAD_IN, 1, -1, -1, 1, 1'b1);
        write_spacing(16'd1);
        send_segment(FUNC_BODY, 0, 0, 7, -9, 1'b1);
        send_segment(FUNC_LEAD_OUT, -3, 3, 3, -3, 1'b1);

        // Random phases over a range of spacings
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: write_spacing(16'd300);
                1: write_spacing(16'($urandom_range(1, 50)));
                2: write_spacing(16'($urandom_range(500, 3000)));
                3: write_spacing(16'd2);
                4: write_spacing(16'($urandom()));
                default: write_spacing(16'd40);
            endcase
            for (int k = 0; k < 47; k++)
                random_segment(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4000));
        end

        drain();
        $display("Covered %0d segments and %0d checked points over ten spacing settings.",
                 segments, sb.checked);
        if (sb.errors == 0 && sb.pending_points.size() == 0)
            $display("** laser_line_point_generator_top: PASSED **");
        else
            $display("** laser_line_point_generator_top: FAILED **");
        $finish;
    end
endmodule
